/* src/ale_pkg.sv */
// Shared types and constants for the associated Legendre evaluator.
package ale_pkg;

	localparam int WORD_W    = 64;   // working value width
	localparam int MB_W      = 33;   // multiplier operand B width
	localparam int ROOT_W    = 32;   // square root result width
	localparam int VAL_W     = 63;   // result value width
	localparam int WORK_FRAC = 32;
	localparam int ROOT_FRAC = 31;
	localparam int OUT_FRAC  = 24;

	// Product shift selection for the serial multiplier
	typedef enum logic [1:0] {
		SH_NONE = 2'd0,
		SH_X    = 2'd1,
		SH_ROOT = 2'd2
	} mshift_t;

	typedef struct packed {
		logic    start;
		mshift_t sh;
	} mul_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	// Magnitude of a signed working value
	function automatic logic [WORD_W-1:0] mag64(input logic signed [WORD_W-1:0] v);
		mag64 = v[WORD_W-1] ? (~v + 64'd1) : v;
	endfunction

	// Apply a sign to a magnitude
	function automatic logic signed [WORD_W-1:0] sgn64(input logic [WORD_W-1:0] m,
			input logic neg);
		sgn64 = neg ? (~m + 64'd1) : m;
	endfunction

endpackage

/* src/ale_if.sv */
// Request, result and configuration channel interfaces.
interface ale_in_if;
	logic               valid;
	logic               ready;
	logic [3:0]         order;
	logic signed [31:0] arg_x;
	modport source (output valid, order, arg_x, input ready);
	modport sink   (input valid, order, arg_x, output ready);
endinterface

interface ale_out_if;
	logic               valid;
	logic               ready;
	logic signed [62:0] value;
	logic               status;
	modport source (output valid, value, status, input ready);
	modport sink   (input valid, value, status, output ready);
endinterface

interface ale_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

/* src/ale_mul.sv */
// Bit-serial shift-add multiplier, one bit of operand B per cycle.
module ale_mul import ale_pkg::*; #(
	parameter int X_FRAC_BITS = 30
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mul_ctl_t          ctl,
	input  logic [WORD_W-1:0] a,
	input  logic [MB_W-1:0]   b,
	output unit_sts_t         sts,
	output logic [WORD_W-1:0] p
);
	localparam int P_W   = WORD_W + MB_W;
	localparam int CNT_W = $clog2(MB_W + 1);

	logic [P_W-1:0]    p_q;
	logic [WORD_W-1:0] a_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;
	mshift_t           sh_q;
	logic [WORD_W:0]   sum;

	// Partial sum of the current step
	assign sum = {1'b0, p_q[P_W-1:MB_W]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MB_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Product register: accumulator on top, multiplier bits shifted out below
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			p_q  <= {{WORD_W{1'b0}}, b};
			a_q  <= a;
			sh_q <= ctl.sh;
		end else if (busy_q) begin
			p_q <= {sum, p_q[MB_W-1:1]};
		end
	end

	// Truncating scale of the finished product
	always_comb begin
		unique case (sh_q)
			SH_X:    p = p_q[X_FRAC_BITS +: WORD_W];
			SH_ROOT: p = p_q[ROOT_FRAC +: WORD_W];
			default: p = p_q[WORD_W-1:0];
		endcase
	end

	assign sts = '{busy: busy_q, done: done_q};
endmodule

/* src/ale_sqrt.sv */
// Digit-serial integer square root, two radicand bits per cycle.
module ale_sqrt import ale_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] v,
	output unit_sts_t         sts,
	output logic [ROOT_W-1:0] root
);
	localparam int CNT_W = $clog2(ROOT_W + 1);
	localparam int REM_W = ROOT_W + 3;

	logic [WORD_W-1:0] rad_q;
	logic [REM_W-1:0]  rem_q, rem_n, trial;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;

	assign rem_n = {rem_q[REM_W-3:0], rad_q[WORD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring root step
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= v;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[WORD_W-3:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign sts  = '{busy: busy_q, done: done_q};
endmodule

/* src/ale_div.sv */
// Bit-serial restoring divider of a 64-bit magnitude by a small divisor.
module ale_div import ale_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] num,
	input  logic [3:0]        den,
	output unit_sts_t         sts,
	output logic [WORD_W-1:0] quo
);
	localparam int CNT_W = $clog2(WORD_W + 1);

	logic [WORD_W-1:0] q_q;
	logic [3:0]        r_q, d_q;
	logic [4:0]        r_n, r_sub;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;

	assign r_n   = {r_q, q_q[WORD_W-1]};
	assign r_sub = r_n - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WORD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (r_n >= {1'b0, d_q}) begin
				r_q <= r_sub[3:0];
				q_q <= {q_q[WORD_W-2:0], 1'b1};
			end else begin
				r_q <= r_n[3:0];
				q_q <= {q_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
	assign sts = '{busy: busy_q, done: done_q};
endmodule

/* src/associated_legendre_eval_top.sv */
// Associated Legendre function evaluator P_l^m(x), top level and sequencer.
//
//   channel  dir  payload                         handshake
//   cfg      in   data[3:0]  degree l             valid/ready, always ready
//   in_req   in   order[3:0], arg_x[31:0] Q1.30   valid/ready
//   res      out  value[62:0] Q38.24, status      valid/ready
//
// One request at a time. The multiplier works through the 33 operand bits
// serially, as do the root and each division. The start value takes m
// passes when m > 0, then come the first step in l and each further
// recurrence step; bad arguments go straight to the result.
// Reset returns degree to 6 and idles the unit.
// A stalled result holds in its register; the next request may be taken then.
module associated_legendre_eval_top import ale_pkg::*; #(
	parameter int MAX_DEGREE  = 8,
	parameter int X_FRAC_BITS = 30
) (
	input  logic   clk,
	input  logic   arst_n,
	ale_cfg_if.sink    cfg,
	ale_in_if.sink     in_req,
	ale_out_if.source  res
);
	localparam logic [32:0] ONE   = 33'd1 << X_FRAC_BITS;
	localparam int          SQ_SH = 2*ROOT_FRAC - 2*X_FRAC_BITS;
	localparam int          DROP  = WORK_FRAC - OUT_FRAC;

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_U    = 12'b000000000010,
		S_SQ   = 12'b000000000100,
		S_PF   = 12'b000000001000,
		S_PR   = 12'b000000010000,
		S_AA   = 12'b000000100000,
		S_AX   = 12'b000001000000,
		S_RA   = 12'b000010000000,
		S_RX   = 12'b000100000000,
		S_RB   = 12'b001000000000,
		S_RD   = 12'b010000000000,
		S_OUT  = 12'b100000000000
	} state_t;

	state_t                   st_q;
	logic                     go_q, bad_q, xneg_q, xneg_in;
	logic [3:0]               degree_q, m_q, i_q, ll_q;
	logic [4:0]               fact_q;
	logic [32:0]              ax_q, ax_in;
	logic [ROOT_W-1:0]        root_q;
	logic signed [WORD_W-1:0] pmm_q, pm1_q, tmp_q, mres, fin;
	logic [WORD_W-1:0]        fmag;
	logic                     ov_q, status_q;
	logic signed [VAL_W-1:0]  value_q;
	logic                     acc;
	logic                     out_take;

	mul_ctl_t          mctl;
	unit_sts_t         msts, ssts, dsts;
	logic [WORD_W-1:0] ma, mp, dquo;
	logic [MB_W-1:0]   mb;
	logic              mneg, sq_start, dv_start;
	logic [ROOT_W-1:0] sq_root;
	logic [3:0]        dden;

	// Configuration register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			degree_q <= 4'd6;
		else if (cfg.valid)
			degree_q <= cfg.data;
	end

	assign in_req.ready = (st_q == S_IDLE);
	assign acc          = in_req.valid && in_req.ready;
	assign xneg_in      = in_req.arg_x[31];
	assign ax_in        = xneg_in ? (33'h1_0000_0000 - {1'b0, in_req.arg_x})
	                              : {1'b0, in_req.arg_x};

	// Multiplier operand selection
	always_comb begin
		ma         = mag64(pmm_q);
		mb         = '0;
		mneg       = pmm_q[WORD_W-1];
		mctl.sh    = SH_NONE;
		mctl.start = go_q && (st_q == S_U || st_q == S_PF || st_q == S_PR ||
			st_q == S_AA || st_q == S_AX || st_q == S_RA || st_q == S_RX ||
			st_q == S_RB);
		unique case (st_q)
			S_U: begin
				ma   = {31'd0, ONE - ax_q};
				mb   = ONE + ax_q;
				mneg = 1'b0;
			end
			S_PF: mb = {28'd0, fact_q};
			S_PR: begin
				ma      = mag64(tmp_q);
				mb      = {1'b0, root_q};
				mneg    = !tmp_q[WORD_W-1];
				mctl.sh = SH_ROOT;
			end
			S_AA: mb = {28'd0, m_q, 1'b1};
			S_AX, S_RX: begin
				ma      = mag64(tmp_q);
				mb      = ax_q;
				mneg    = tmp_q[WORD_W-1] ^ xneg_q;
				mctl.sh = SH_X;
			end
			S_RA: begin
				ma   = mag64(pm1_q);
				mb   = {28'd0, ll_q, 1'b0} - 33'd1;
				mneg = pm1_q[WORD_W-1];
			end
			S_RB: mb = {29'd0, ll_q + m_q - 4'd1};
			default: ;
		endcase
	end
	assign mres     = sgn64(mp, mneg);
	assign sq_start = go_q && (st_q == S_SQ);
	assign dv_start = go_q && (st_q == S_RD);
	assign dden     = ll_q - m_q;
	assign out_take = (st_q == S_OUT) && (!ov_q || res.ready);

	ale_mul #(.X_FRAC_BITS(X_FRAC_BITS)) u_mul (
		.clk, .arst_n, .ctl(mctl), .a(ma), .b(mb), .sts(msts), .p(mp)
	);

	ale_sqrt u_sqrt (
		.clk, .arst_n, .start(sq_start), .v(mp << SQ_SH), .sts(ssts), .root(sq_root)
	);

	ale_div u_div (
		.clk, .arst_n, .start(dv_start), .num(mag64(tmp_q)), .den(dden),
		.sts(dsts), .quo(dquo)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			go_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (out_take)
				ov_q <= 1'b1;
			else if (res.ready)
				ov_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (acc) begin
					go_q <= 1'b1;
					if (degree_q > 4'(MAX_DEGREE) || in_req.order > degree_q || ax_in > ONE)
						st_q <= S_OUT;
					else if (in_req.order != 4'd0)
						st_q <= S_U;
					else if (degree_q != 4'd0)
						st_q <= S_AA;
					else
						st_q <= S_OUT;
				end
				S_U: if (msts.done) begin
					st_q <= S_SQ;
					go_q <= 1'b1;
				end
				S_SQ: if (ssts.done) begin
					st_q <= S_PF;
					go_q <= 1'b1;
				end
				S_PF: if (msts.done) begin
					st_q <= S_PR;
					go_q <= 1'b1;
				end
				S_PR: if (msts.done) begin
					go_q <= 1'b1;
					if (i_q != m_q)
						st_q <= S_PF;
					else if (degree_q > m_q)
						st_q <= S_AA;
					else
						st_q <= S_OUT;
				end
				S_AA: if (msts.done) begin
					st_q <= S_AX;
					go_q <= 1'b1;
				end
				S_AX: if (msts.done) begin
					go_q <= 1'b1;
					st_q <= ({1'b0, m_q} + 5'd2 > {1'b0, degree_q}) ? S_OUT : S_RA;
				end
				S_RA: if (msts.done) begin
					st_q <= S_RX;
					go_q <= 1'b1;
				end
				S_RX: if (msts.done) begin
					st_q <= S_RB;
					go_q <= 1'b1;
				end
				S_RB: if (msts.done) begin
					st_q <= S_RD;
					go_q <= 1'b1;
				end
				S_RD: if (dsts.done) begin
					go_q <= 1'b1;
					st_q <= (ll_q >= degree_q) ? S_OUT : S_RA;
				end
				S_OUT: if (out_take) begin
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Working values
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: if (acc) begin
				m_q    <= in_req.order;
				ax_q   <= ax_in;
				xneg_q <= xneg_in;
				bad_q  <= degree_q > 4'(MAX_DEGREE) || in_req.order > degree_q || ax_in > ONE;
				pmm_q  <= 64'sd1 <<< WORK_FRAC;
				i_q    <= 4'd1;
				fact_q <= 5'd1;
			end
			S_SQ: if (ssts.done) root_q <= sq_root;
			S_PF, S_AA, S_RA, S_RX: if (msts.done) tmp_q <= mres;
			S_PR: if (msts.done) begin
				pmm_q  <= mres;
				i_q    <= i_q + 4'd1;
				fact_q <= fact_q + 5'd2;
			end
			S_AX: if (msts.done) begin
				pm1_q <= mres;
				ll_q  <= m_q + 4'd2;
			end
			S_RB: if (msts.done) tmp_q <= tmp_q - mres;
			S_RD: if (dsts.done) begin
				pmm_q <= pm1_q;
				pm1_q <= sgn64(dquo, tmp_q[WORD_W-1]);
				ll_q  <= ll_q + 4'd1;
			end
			default: ;
		endcase
	end

	// Result scaling to Q38.24, toward zero
	assign fin  = (degree_q > m_q) ? pm1_q : pmm_q;
	assign fmag = mag64(fin) >> DROP;

	always_ff @(posedge clk) begin
		if (out_take) begin
			status_q <= bad_q;
			value_q  <= bad_q ? '0 : VAL_W'(sgn64(fmag, fin[WORD_W-1]));
		end
	end

	assign res.valid  = ov_q;
	assign res.value  = value_q;
	assign res.status = status_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> st_q != S_IDLE) else $error("request accepted but sequencer idle");
	a_mul_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mctl.start |-> !msts.busy) else $error("multiplier restarted while busy");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		dv_start |-> dden != 4'd0) else $error("division by zero");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status) |-> res.value == '0) else $error("bad result not zero");
endmodule

/* dv/associated_legendre_eval_top_test.sv */
// Self-checking testbench for the associated Legendre evaluator top level.
module associated_legendre_eval_top_test import ale_pkg::*; ();

	typedef struct packed {
		logic signed [62:0] value;
		logic               status;
	} ale_res_t;

	typedef struct {
		logic [3:0]         order;
		logic signed [31:0] arg_x;
		logic               known;
		logic signed [62:0] value;
		logic               status;
	} dir_row_t;

	localparam logic [31:0] X_ONE     = 32'h4000_0000;
	localparam int          WATCH_MAX = 200000;

	logic clk;
	logic arst_n;

	ale_cfg_if cfg_ch();
	ale_in_if  req_ch();
	ale_out_if res_ch();

	associated_legendre_eval_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.in_req (req_ch),
		.res    (res_ch)
	);

	// Predictor state and pending results
	logic [3:0] model_degree;
	ale_res_t   pending_res[$];
	ale_res_t   typed_res[$];
	logic       typed_known[$];
	int         n_fail, n_mism, n_req, n_res, n_bad;
	int         idle_off;  // when set, neither side idles
	int         hold_rx;   // receiver hold-off cycles remaining
	int         watch;

	// floor(a*b / 2^s), a below 2^62
	function automatic logic [63:0] umulsh(input logic [63:0] a, input logic [63:0] b,
			input int s);
		logic [127:0] p;
		p = a * b;
		return p[63+s -: 64];
	endfunction

	function automatic logic signed [63:0] smulsh(input logic signed [63:0] a,
			input logic [63:0] b, input logic bneg, input int s);
		logic neg;
		logic [63:0] m, r;
		neg = (a < 0) != bneg;
		m = (a < 0) ? -a : a;
		r = umulsh(m, b, s);
		return neg ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] r, bt;
		r = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt = bt >> 2;
		while (bt != 0) begin
			if (v >= r + bt) begin
				v = v - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	// P_l^m(x) as the block computes it
	function automatic ale_res_t legendre_eval(input logic [3:0] m,
			input logic signed [31:0] x, input logic [3:0] l);
		ale_res_t o;
		logic xneg;
		logic [63:0] ax, u, rt, rmag;
		logic signed [63:0] pmm, pm1, pl, t1, t2, fact, rv;
		int ll;
		xneg = x[31];
		ax = xneg ? (64'h1_0000_0000 - {32'd0, x}) : {32'd0, x};
		if (l > 8 || m > l || ax > X_ONE) begin
			o.value = '0;
			o.status = 1'b1;
			return o;
		end
		pmm = 64'sd1 <<< WORK_FRAC;
		if (m > 0) begin
			u = (X_ONE - ax) * (X_ONE + ax);
			rt = root64(u << 2);
			fact = 1;
			for (int i = 1; i <= m; i++) begin
				pmm = -smulsh(pmm * fact, rt, 1'b0, ROOT_FRAC);
				fact = fact + 2;
			end
		end
		rv = pmm;
		if (l > m) begin
			pm1 = smulsh((2 * m + 1) * pmm, ax, xneg, 30);
			for (ll = m + 2; ll <= l; ll++) begin
				t1 = smulsh((2 * ll - 1) * pm1, ax, xneg, 30);
				t2 = (ll + m - 1) * pmm;
				pl = (t1 - t2) / (ll - int'(m));
				pmm = pm1;
				pm1 = pl;
			end
			rv = pm1;
		end
		rmag = (rv < 0) ? -rv : rv;
		rmag = rmag >> (WORK_FRAC - OUT_FRAC);
		rmag = (rv < 0) ? -rmag : rmag;
		o.value = rmag[62:0];
		o.status = 1'b0;
		return o;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		req_ch.valid = 1'b0;
		req_ch.order = '0;
		req_ch.arg_x = '0;
		res_ch.ready = 1'b0;
		idle_off = 0;
		hold_rx = 0;
	end

	// Result side: random stalls plus a long hold-off when asked
	always @(negedge clk) begin
		if (hold_rx > 0) begin
			hold_rx <= hold_rx - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= idle_off ? 1'b1 : ($urandom_range(99) >= 6);
		end
	end

	// Check results, count accepted requests and results
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				watch <= 0;
			else
				watch <= watch + 1;
			if (req_ch.valid && req_ch.ready)
				n_req <= n_req + 1;
			if (res_ch.valid && res_ch.ready) begin
				n_res <= n_res + 1;
				if (pending_res.size() == 0) begin
					n_fail++;
					$display("unexpected result value=%h status=%b", res_ch.value,
						res_ch.status);
				end else begin
					ale_res_t e;
					e = pending_res.pop_front();
					if (typed_known.pop_front() && typed_res.pop_front() != e) begin
						n_fail++;
						$display("table entry disagrees with predictor");
					end else if (typed_res.size() > pending_res.size()) begin
						void'(typed_res.pop_front());
					end
					if (res_ch.value !== e.value || res_ch.status !== e.status) begin
						n_fail++;
						n_mism++;
						if (n_mism <= 10)
							$display("mismatch: exp value=%h status=%b got value=%h status=%b",
								e.value, e.status, res_ch.value, res_ch.status);
					end
				end
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (watch >= WATCH_MAX) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_degree(input logic [3:0] d);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		model_degree = d;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Offer one request, expectation recorded at acceptance
	task automatic send_req(input logic [3:0] m, input logic signed [31:0] x,
			input logic known, input ale_res_t typed);
		if (!idle_off)
			while ($urandom_range(99) < 6) begin
				req_ch.valid <= 1'b0;
				@(negedge clk);
			end
		req_ch.valid <= 1'b1;
		req_ch.order <= m;
		req_ch.arg_x <= x;
		do @(posedge clk); while (!req_ch.ready);
		pending_res.push_back(legendre_eval(m, x, model_degree));
		typed_known.push_back(known);
		typed_res.push_back(typed);
		if (pending_res[$].status)
			n_bad++;
		@(negedge clk);
	endtask

	task automatic drain;
		req_ch.valid <= 1'b0;
		while (pending_res.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_x;
		int k;
		k = $urandom_range(99);
		if (k < 10) return $urandom;
		if (k < 20) return (k & 1) ? X_ONE : -X_ONE;
		if (k < 25) return (k & 1) ? X_ONE + 1 : -(X_ONE + 1);
		return $signed($urandom_range(32'h8000_0000)) - $signed(X_ONE);
	endfunction

	dir_row_t dir_tab[] = '{
		'{4'd0, 32'sh4000_0000, 1'b1, 63'sh100_0000, 1'b0},
		'{4'd0, -32'sh4000_0000, 1'b1, 63'sh100_0000, 1'b0},
		'{4'd7, 32'sd0, 1'b1, 63'sd0, 1'b1},
		'{4'd15, 32'sd0, 1'b1, 63'sd0, 1'b1},
		'{4'd0, 32'sh4000_0001, 1'b1, 63'sd0, 1'b1},
		'{4'd0, -32'sh4000_0001, 1'b1, 63'sd0, 1'b1},
		'{4'd0, 32'sh7fff_ffff, 1'b1, 63'sd0, 1'b1},
		'{4'd0, 32'sh8000_0000, 1'b1, 63'sd0, 1'b1},
		'{4'd6, 32'sd0, 1'b0, 63'sd0, 1'b0},
		'{4'd6, 32'sh4000_0000, 1'b0, 63'sd0, 1'b0},
		'{4'd3, 32'sh2000_0000, 1'b0, 63'sd0, 1'b0},
		'{4'd1, -32'sh1234_5678, 1'b0, 63'sd0, 1'b0},
		'{4'd2, 32'sd1, 1'b0, 63'sd0, 1'b0},
		'{4'd5, -32'sh3fff_ffff, 1'b0, 63'sd0, 1'b0},
		'{4'd0, 32'sh2aaa_aaaa, 1'b0, 63'sd0, 1'b0}
	};

	initial begin
		ale_res_t t;
		int       nrand;
		n_fail = 0; n_mism = 0; n_req = 0; n_res = 0; n_bad = 0; watch = 0;
		model_degree = 4'd6;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table at the reset degree
		foreach (dir_tab[i]) begin
			t.value = dir_tab[i].value;
			t.status = dir_tab[i].status;
			send_req(dir_tab[i].order, dir_tab[i].arg_x, dir_tab[i].known, t);
		end
		drain();
		write_degree(4'd15);  // out of range degree rejects everything
		t = '{63'sd0, 1'b1};
		send_req(4'd0, 32'sd0, 1'b1, t);
		drain();
		write_degree(4'd8);
		send_req(4'd8, 32'sd0, 1'b0, t);
		send_req(4'd0, 32'sh4000_0000, 1'b1, '{63'sh100_0000, 1'b0});
		drain();

		// Random phases over a range of degrees
		for (int ph = 0; ph < 10; ph++) begin
			write_degree(ph == 0 ? 4'd0 : ph == 1 ? 4'd8 : ph == 9 ? 4'd15 :
				$urandom_range(8));
			idle_off = (ph == 3);
			nrand = (ph == 9) ? 50 : 155;
			for (int k = 0; k < nrand; k++) begin
				if (ph == 5 && k == 10) hold_rx = 2000;
				send_req($urandom_range(99) < 85 ? $urandom_range(model_degree > 8 ?
					8 : model_degree) : $urandom_range(15), rand_x(), 1'b0, t);
			end
			drain();
		end
		idle_off = 0;

		$display("covered %0d requests (%0d bad arguments), %0d results, degrees 0..15",
			n_req, n_bad, n_res);
		if (n_fail == 0 && pending_res.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* files.f */
src/ale_pkg.sv
src/ale_if.sv
src/ale_mul.sv
src/ale_sqrt.sv
src/ale_div.sv
src/associated_legendre_eval_top.sv
dv/associated_legendre_eval_top_test.sv
